[sv/bbc_pkg.sv]
// Shared types and constants for the LRU block buffer cache.
`default_nettype none

package bbc_pkg;

  // Default configuration
  localparam int NUM_SLOTS_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 8;

  // Fixed field widths of the request and result
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int SLOT_F_W = 5;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_PIN     = 2'd2,
    KIND_UNPIN   = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_UNDER  = 2'd2,
    STAT_OVER   = 2'd3
  } status_t;

  // Request payload
  typedef struct packed {
    kind_t               kind;
    logic [DEV_W-1:0]    device;
    logic [BLK_W-1:0]    block_number;
    logic [SLOT_F_W-1:0] slot;
  } in_t;

  // Result payload
  typedef struct packed {
    logic [SLOT_F_W-1:0] slot_out;
    logic                hit;
    logic                need_fetch;
    status_t             status;
  } out_t;

endpackage

`default_nettype wire

[sv/bbc_mem.sv]
// Slot bookkeeping memory: one write port, one registered read port.
`default_nettype none

module bbc_mem #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 8,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/bbc_ctrl.sv]
// Sequencer for the buffer cache: scans, read-modify-write and recency sweep.
`default_nettype none

module bbc_ctrl #(
  parameter  int NUM_SLOTS   = bbc_pkg::NUM_SLOTS_DEF,
  parameter  int COUNT_WIDTH = bbc_pkg::COUNT_WIDTH_DEF,
  localparam int SLOT_W      = $clog2(NUM_SLOTS),
  localparam int ENTRY_W     = bbc_pkg::DEV_W + bbc_pkg::BLK_W + 1 + COUNT_WIDTH + SLOT_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bbc_pkg::in_t         in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bbc_pkg::out_t             out_data,
  // memory port
  output logic                      mem_we,
  output logic [SLOT_W-1:0]         mem_waddr,
  output logic [ENTRY_W-1:0]        mem_wdata,
  output logic                      mem_re,
  output logic [SLOT_W-1:0]         mem_raddr,
  input  wire logic [ENTRY_W-1:0]   mem_rdata
);

  import bbc_pkg::*;

  localparam logic [SLOT_W-1:0]      LAST      = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // One slot's bookkeeping as stored in memory
  typedef struct packed {
    logic [DEV_W-1:0]       dev;
    logic [BLK_W-1:0]       blk;
    logic                   valid;
    logic [COUNT_WIDTH-1:0] count;
    logic [SLOT_W-1:0]      rank;
  } entry_t;

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_SCAN     = 9'b000000100,
    ST_SCAN_END = 9'b000001000,
    ST_DECIDE   = 9'b000010000,
    ST_MODIFY   = 9'b000100000,
    ST_RANK     = 9'b001000000,
    ST_RANK_END = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic                rv_r;
  logic [SLOT_W-1:0]   raddr_q_r;
  in_t                 req_r, req_nxt;
  out_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  // best tag match (highest rank) and best free slot (lowest rank)
  logic                   m_found_r, m_found_nxt;
  logic [SLOT_W-1:0]      m_idx_r, m_idx_nxt;
  logic [SLOT_W-1:0]      m_rank_r, m_rank_nxt;
  logic [COUNT_WIDTH-1:0] m_count_r, m_count_nxt;
  logic                   m_valid_r, m_valid_nxt;
  logic                   f_found_r, f_found_nxt;
  logic [SLOT_W-1:0]      f_idx_r, f_idx_nxt;
  logic [SLOT_W-1:0]      f_rank_r, f_rank_nxt;
  logic [SLOT_W-1:0]      piv_rank_r, piv_rank_nxt;

  entry_t              rd_e;
  entry_t              wr_e;
  logic                in_acc;
  logic                tag_match;
  logic [SLOT_W-1:0]   req_slot;

  assign rd_e      = entry_t'(mem_rdata);
  assign mem_wdata = ENTRY_W'(wr_e);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign tag_match = (rd_e.dev == req_r.device) && (rd_e.blk == req_r.block_number);
  assign req_slot  = SLOT_W'(req_r.slot);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    m_found_nxt   = m_found_r;
    m_idx_nxt     = m_idx_r;
    m_rank_nxt    = m_rank_r;
    m_count_nxt   = m_count_r;
    m_valid_nxt   = m_valid_r;
    f_found_nxt   = f_found_r;
    f_idx_nxt     = f_idx_r;
    f_rank_nxt    = f_rank_r;
    piv_rank_nxt  = piv_rank_r;
    mem_we        = 1'b0;
    mem_waddr     = raddr_q_r;
    wr_e          = rd_e;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r;

    // result handed off to the consumer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // scan bookkeeping while data streams in
    if ((state_r == ST_SCAN || state_r == ST_SCAN_END) && rv_r) begin
      if (tag_match && (!m_found_r || rd_e.rank > m_rank_r)) begin
        m_found_nxt = 1'b1;
        m_idx_nxt   = raddr_q_r;
        m_rank_nxt  = rd_e.rank;
        m_count_nxt = rd_e.count;
        m_valid_nxt = rd_e.valid;
      end
      if (rd_e.count == '0 && (!f_found_r || rd_e.rank < f_rank_r)) begin
        f_found_nxt = 1'b1;
        f_idx_nxt   = raddr_q_r;
        f_rank_nxt  = rd_e.rank;
      end
    end

    // recency sweep write-back
    if ((state_r == ST_RANK || state_r == ST_RANK_END) && rv_r) begin
      mem_we = 1'b1;
      if (raddr_q_r == req_slot) begin
        wr_e.rank = LAST;
      end else if (rd_e.rank > piv_rank_r) begin
        wr_e.rank = rd_e.rank - 1'b1;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        wr_e      = '0;
        wr_e.rank = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt     = in_data;
          m_found_nxt = 1'b0;
          f_found_nxt = 1'b0;
          cnt_nxt     = '0;
          if (in_data.kind == KIND_READ) begin
            state_nxt = ST_SCAN;
          end else if (32'(in_data.slot) >= NUM_SLOTS) begin
            res_nxt.slot_out   = in_data.slot;
            res_nxt.hit        = 1'b0;
            res_nxt.need_fetch = 1'b0;
            res_nxt.status     = STAT_OK;
            state_nxt          = ST_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = SLOT_W'(in_data.slot);
            state_nxt = ST_MODIFY;
          end
        end
      end
      ST_SCAN: begin
        mem_re  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_nxt.hit        = 1'b0;
        res_nxt.need_fetch = 1'b0;
        res_nxt.status     = STAT_OK;
        wr_e.dev           = req_r.device;
        wr_e.blk           = req_r.block_number;
        wr_e.valid         = 1'b1;
        if (m_found_r) begin
          res_nxt.slot_out = SLOT_F_W'(m_idx_r);
          res_nxt.hit      = 1'b1;
          if (m_count_r == COUNT_MAX) begin
            res_nxt.status = STAT_OVER;
          end else begin
            mem_we             = 1'b1;
            mem_waddr          = m_idx_r;
            wr_e.count         = m_count_r + 1'b1;
            wr_e.rank          = m_rank_r;
            res_nxt.need_fetch = !m_valid_r;
          end
        end else if (f_found_r) begin
          mem_we             = 1'b1;
          mem_waddr          = f_idx_r;
          wr_e.count         = COUNT_WIDTH'(1);
          wr_e.rank          = f_rank_r;
          res_nxt.slot_out   = SLOT_F_W'(f_idx_r);
          res_nxt.need_fetch = 1'b1;
        end else begin
          res_nxt.slot_out = '0;
          res_nxt.status   = STAT_NOFREE;
        end
        state_nxt = ST_DONE;
      end
      ST_MODIFY: begin
        // rdata holds the addressed slot
        res_nxt.slot_out   = req_r.slot;
        res_nxt.hit        = 1'b0;
        res_nxt.need_fetch = 1'b0;
        res_nxt.status     = STAT_OK;
        mem_waddr          = req_slot;
        state_nxt          = ST_DONE;
        if (req_r.kind == KIND_PIN) begin
          if (rd_e.count == COUNT_MAX) begin
            res_nxt.status = STAT_OVER;
          end else begin
            mem_we     = 1'b1;
            wr_e.count = rd_e.count + 1'b1;
          end
        end else if (rd_e.count == '0) begin
          res_nxt.status = STAT_UNDER;
        end else begin
          mem_we     = 1'b1;
          wr_e.count = rd_e.count - 1'b1;
          if (req_r.kind == KIND_RELEASE && rd_e.count == COUNT_WIDTH'(1)) begin
            piv_rank_nxt = rd_e.rank;
            cnt_nxt      = '0;
            state_nxt    = ST_RANK;
          end
        end
      end
      ST_RANK: begin
        mem_re  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_RANK_END;
        end
      end
      ST_RANK_END: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= mem_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    raddr_q_r  <= mem_raddr;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    m_found_r  <= m_found_nxt;
    m_idx_r    <= m_idx_nxt;
    m_rank_r   <= m_rank_nxt;
    m_count_r  <= m_count_nxt;
    m_valid_r  <= m_valid_nxt;
    f_found_r  <= f_found_nxt;
    f_idx_r    <= f_idx_nxt;
    f_rank_r   <= f_rank_nxt;
    piv_rank_r <= piv_rank_nxt;
  end

  // Sweep never reads the entry it writes back in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same slot");

  // Last scan data is present when the scan closes
  a_scan_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_END || state_r == ST_RANK_END) |-> rv_r)
    else $error("scan tail without read data");

  // Sweep starts from slot zero
  a_rank_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MODIFY && state_nxt == ST_RANK |=> cnt_r == '0 && !rv_r)
    else $error("recency sweep misaligned");

  // A failed request never asks for a fetch
  a_err_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != STAT_OK |-> !out_data_r.need_fetch)
    else $error("fetch flagged on failed request");

endmodule

`default_nettype wire

[sv/block_buffer_cache_lru_top.sv]
// LRU block buffer cache (tags, reference counts, recency): top level.
//
// Keeps NUM_SLOTS buffer slots in one synchronous memory, one entry per slot
// holding device and block tags, a valid mark, a COUNT_WIDTH-bit reference
// count and a recency rank. After reset a clearing pass over every slot
// initializes the memory; no request is taken during it. A read request
// scans every slot once, one slot a cycle through the memory read port. A
// release that drops a count to zero sweeps all slots again to update the
// ranks. One request is handled at a time; a new one is taken while the
// previous result still waits in the output register.
`default_nettype none

module block_buffer_cache_lru_top #(
  parameter int NUM_SLOTS   = bbc_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = bbc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bbc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bbc_pkg::out_t      out_data
);

  import bbc_pkg::*;

  localparam int SlotW  = $clog2(NUM_SLOTS);
  localparam int EntryW = DEV_W + BLK_W + 1 + COUNT_WIDTH + SlotW;

  logic              mem_we;
  logic [SlotW-1:0]  mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_re;
  logic [SlotW-1:0]  mem_raddr;
  logic [EntryW-1:0] mem_rdata;

  // Sequencer
  bbc_ctrl #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Slot memory
  bbc_mem #(
    .DEPTH  (NUM_SLOTS),
    .DATA_W (EntryW),
    .ADDR_W (SlotW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

[sim/bbc_checker.sv]
// Checker for the LRU block buffer cache: tracks the cache state and compares every result.
module bbc_checker #(
  parameter int NUM_SLOTS   = bbc_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = bbc_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  bbc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  bbc_pkg::out_t out_data,
  output int            errors,
  output int            leftover
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] REFS_FULL = '1;

  // Shadow copy of the slot table
  logic [DEV_W-1:0]       tag_dev [NUM_SLOTS];
  logic [BLK_W-1:0]       tag_blk [NUM_SLOTS];
  logic                   filled  [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] refs    [NUM_SLOTS];
  int unsigned            rank    [NUM_SLOTS];

  out_t results_due [$];
  out_t due;
  int   mismatches = 0;

  // Apply one request to the shadow table and return the result it should give
  function automatic out_t cache_step(input in_t req);
    out_t        res;
    int          pick;
    bit          found;
    int unsigned old_rank;
    int          s;
    res.slot_out   = req.slot;
    res.hit        = 1'b0;
    res.need_fetch = 1'b0;
    res.status     = STAT_OK;
    pick           = 0;
    found          = 1'b0;
    s              = int'(req.slot);
    if (req.kind == KIND_READ) begin
      // most recent slot whose tags match, filled or not
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (tag_dev[i] == req.device && tag_blk[i] == req.block_number &&
            (!found || rank[i] > rank[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        res.slot_out = SLOT_F_W'(pick);
        res.hit      = 1'b1;
        if (refs[pick] == REFS_FULL) begin
          res.status = STAT_OVER;
        end else begin
          refs[pick]++;
          res.need_fetch = !filled[pick];
          filled[pick]   = 1'b1;
        end
      end else begin
        // miss: least recent slot nobody holds
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (refs[i] == '0 && (!found || rank[i] < rank[pick])) begin
            pick  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          res.slot_out = '0;
          res.status   = STAT_NOFREE;
        end else begin
          tag_dev[pick]  = req.device;
          tag_blk[pick]  = req.block_number;
          refs[pick]     = COUNT_WIDTH'(1);
          filled[pick]   = 1'b1;
          res.slot_out   = SLOT_F_W'(pick);
          res.need_fetch = 1'b1;
        end
      end
    end else if (s < NUM_SLOTS) begin
      // a slot beyond the cache is only echoed back
      if (req.kind == KIND_PIN) begin
        if (refs[s] == REFS_FULL) res.status = STAT_OVER;
        else refs[s]++;
      end else if (refs[s] == '0) begin
        res.status = STAT_UNDER;
      end else begin
        refs[s]--;
        // release to zero moves the slot to the top; unpin leaves recency alone
        if (req.kind == KIND_RELEASE && refs[s] == '0) begin
          old_rank = rank[s];
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (rank[i] > old_rank) rank[i]--;
          end
          rank[s] = NUM_SLOTS - 1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        filled[i]  = 1'b0;
        refs[i]    = '0;
        rank[i]    = i;
      end
      results_due.delete();
    end else begin
      // compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("checker: unexpected result slot %0d hit %0b fetch %0b status %0d",
                     out_data.slot_out, out_data.hit, out_data.need_fetch, out_data.status);
          end
        end else begin
          due = results_due.pop_front();
          if (out_data.slot_out !== due.slot_out || out_data.hit !== due.hit ||
              out_data.need_fetch !== due.need_fetch || out_data.status !== due.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: mismatch %0d: expected slot %0d hit %0b fetch %0b status %0d",
                       mismatches, due.slot_out, due.hit, due.need_fetch, due.status);
              $display("checker:   got slot %0d hit %0b fetch %0b status %0d",
                       out_data.slot_out, out_data.hit, out_data.need_fetch, out_data.status);
            end
          end
        end
      end
      // predict each accepted request
      if (in_valid && !in_stall) results_due.push_back(cache_step(in_data));
    end
    errors   <= mismatches;
    leftover <= results_due.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the LRU block buffer cache: clock, reset, requests and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int NUM_SLOTS        = NUM_SLOTS_DEF;
  localparam int COUNT_WIDTH      = COUNT_WIDTH_DEF;
  localparam int RANDOM_PER_PHASE = 400;
  localparam int POOL_SIZE        = 8;
  localparam int QUIET_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 3 * (NUM_SLOTS + 4);

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   errors;
  int   leftover;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int req_cnt      = 0;
  int res_cnt      = 0;
  int hit_cnt      = 0;
  int fetch_cnt    = 0;
  int kind_cnt   [4];
  int status_cnt [4];
  out_t last_res;

  // slots granted by reads and not yet handed back
  logic [SLOT_F_W-1:0] held [$];
  // small working set of tags so reads hit often
  logic [DEV_W-1:0]    pool_dev [POOL_SIZE];
  logic [BLK_W-1:0]    pool_blk [POOL_SIZE];

  always #6 clk = ~clk;

  block_buffer_cache_lru_top #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  bbc_checker #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .leftover (leftover)
  );

  // Result-side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // One clock; note what was accepted at this edge
  task automatic tick();
    @(posedge clk);
    if (rst_n && in_valid && !in_stall) begin
      req_cnt++;
      kind_cnt[in_data.kind]++;
    end
    if (rst_n && out_valid && !out_stall) begin
      res_cnt++;
      last_res = out_data;
      status_cnt[out_data.status]++;
      if (out_data.hit) hit_cnt++;
      if (out_data.need_fetch) fetch_cnt++;
      if (out_data.status == STAT_OK && (out_data.hit || out_data.need_fetch)) begin
        held.push_back(out_data.slot_out);
      end
    end
  endtask

  // Offer one request, with random idle cycles ahead of it, until accepted
  task automatic send_req(input in_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      tick();
    end
    in_valid <= 1'b1;
    in_data  <= req;
    tick();
    while (in_stall) tick();
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (res_cnt != req_cnt) tick();
  endtask

  function automatic in_t mk_req(input kind_t kind, input logic [DEV_W-1:0] device,
                                 input logic [BLK_W-1:0] blk,
                                 input logic [SLOT_F_W-1:0] slot);
    in_t r;
    r.kind         = kind;
    r.device       = device;
    r.block_number = blk;
    r.slot         = slot;
    return r;
  endfunction

  // Mostly hand back a slot we hold, otherwise any slot
  function automatic logic [SLOT_F_W-1:0] held_or_any();
    int                  idx;
    logic [SLOT_F_W-1:0] s;
    s = SLOT_F_W'($urandom);
    if (held.size() > 0 && $urandom_range(99) < 70) begin
      idx = $urandom_range(held.size() - 1);
      s   = held[idx];
      held.delete(idx);
    end
    return s;
  endfunction

  // Random mix of reads, releases, pins and unpins
  task automatic random_phase(input int n);
    int                  done;
    int                  pick;
    int                  idx;
    logic [DEV_W-1:0]    dev;
    logic [BLK_W-1:0]    blk;
    logic [SLOT_F_W-1:0] s;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      s    = SLOT_F_W'($urandom);
      if (pick < 40) begin
        // read: working set, sometimes a fresh or an extreme tag
        idx  = $urandom_range(POOL_SIZE - 1);
        dev  = pool_dev[idx];
        blk  = pool_blk[idx];
        pick = $urandom_range(99);
        if (pick < 15) begin
          dev = DEV_W'($urandom);
          blk = $urandom;
          if (pick < 8) begin
            pool_dev[idx] = dev;
            pool_blk[idx] = blk;
          end
        end else if (pick < 25) begin
          dev = $urandom_range(1) ? '1 : '0;
          blk = $urandom_range(1) ? '1 : '0;
        end
        send_req(mk_req(KIND_READ, dev, blk, s));
        done++;
      end else if (pick < 65) begin
        send_req(mk_req(KIND_RELEASE, DEV_W'($urandom), $urandom, held_or_any()));
        done++;
      end else if (pick < 75) begin
        send_req(mk_req(KIND_UNPIN, DEV_W'($urandom), $urandom, held_or_any()));
        done++;
      end else if (pick < 85) begin
        send_req(mk_req(KIND_PIN, DEV_W'($urandom), $urandom, s));
        done++;
      end else if (pick < 98) begin
        // pin then release: the release may bring the slot to the top
        send_req(mk_req(KIND_PIN, DEV_W'($urandom), $urandom, s));
        send_req(mk_req(KIND_RELEASE, DEV_W'($urandom), $urandom, s));
        done += 2;
      end else begin
        // hold every slot so a miss finds no free buffer, then let go
        for (int i = 0; i < NUM_SLOTS; i++) begin
          send_req(mk_req(KIND_PIN, DEV_W'($urandom), $urandom, SLOT_F_W'(i)));
        end
        send_req(mk_req(KIND_READ, DEV_W'($urandom), $urandom, s));
        for (int i = 0; i < NUM_SLOTS; i++) begin
          send_req(mk_req(KIND_RELEASE, DEV_W'($urandom), $urandom, SLOT_F_W'(i)));
        end
        done += 2 * NUM_SLOTS + 1;
      end
    end
  endtask

  initial begin
    in_t                 burst_read;
    logic [SLOT_F_W-1:0] burst_slot;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_dev[i] = DEV_W'($urandom);
      pool_blk[i] = $urandom;
    end
    repeat (12) tick();
    rst_n <= 1'b1;

    // directed: unfilled slots match on tags, hit and miss, underflow,
    // unpin to zero keeps recency, several matches pick the most recent
    send_req(mk_req(KIND_READ, '0, '0, '0));
    send_req(mk_req(KIND_READ, '0, '0, '1));
    send_req(mk_req(KIND_READ, '1, '1, '0));
    send_req(mk_req(KIND_READ, '1, '1, '1));
    send_req(mk_req(KIND_PIN, '1, '1, '0));
    send_req(mk_req(KIND_UNPIN, '0, '0, '0));
    send_req(mk_req(KIND_RELEASE, '0, '1, '0));
    send_req(mk_req(KIND_RELEASE, '1, '0, '0));
    send_req(mk_req(KIND_RELEASE, '0, '0, '0));
    send_req(mk_req(KIND_UNPIN, '0, '0, '0));
    send_req(mk_req(KIND_PIN, '0, '0, '1));
    repeat (3) send_req(mk_req(KIND_UNPIN, '0, '0, '1));
    send_req(mk_req(KIND_UNPIN, '0, '0, '1));
    send_req(mk_req(KIND_READ, '0, '0, '0));
    send_req(mk_req(KIND_READ, 8'h55, 32'hAAAA_AAAA, 5'h0A));
    send_req(mk_req(KIND_READ, 8'hAA, 32'h5555_5555, 5'h15));
    send_req(mk_req(KIND_PIN, 8'h55, 32'h5555_5555, 5'd15));
    send_req(mk_req(KIND_RELEASE, 8'hAA, 32'hAAAA_AAAA, 5'd15));
    send_req(mk_req(KIND_RELEASE, '0, '0, '1));

    // no idling on either side
    random_phase(RANDOM_PER_PHASE);

    // saturate one slot's count: pin overflow, read-hit overflow, drain to underflow
    burst_read = mk_req(KIND_READ, DEV_W'($urandom), $urandom, '0);
    send_req(burst_read);
    drain();
    if (last_res.status == STAT_OK) begin
      burst_slot = last_res.slot_out;
      repeat (1 << COUNT_WIDTH) begin
        send_req(mk_req(KIND_PIN, DEV_W'($urandom), $urandom, burst_slot));
      end
      send_req(burst_read);
      repeat ((1 << COUNT_WIDTH) + 1) begin
        send_req(mk_req(KIND_UNPIN, DEV_W'($urandom), $urandom, burst_slot));
      end
    end

    // sender mostly idle
    idle_pct = 73;
    random_phase(RANDOM_PER_PHASE);
    // receiver mostly stalling
    idle_pct = 0;
    stall_pct <= 73;
    random_phase(RANDOM_PER_PHASE);
    // light idling on both sides
    idle_pct = 6;
    stall_pct <= 6;
    random_phase(RANDOM_PER_PHASE);

    drain();
    repeat (SETTLE_CYCLES) tick();

    $display("summary: %0d requests (%0d read, %0d release, %0d pin, %0d unpin), %0d results",
             req_cnt, kind_cnt[KIND_READ], kind_cnt[KIND_RELEASE], kind_cnt[KIND_PIN],
             kind_cnt[KIND_UNPIN], res_cnt);
    $display("summary: %0d hits, %0d fetches, %0d no-free, %0d underflow, %0d overflow, %0d bad",
             hit_cnt, fetch_cnt, status_cnt[STAT_NOFREE], status_cnt[STAT_UNDER],
             status_cnt[STAT_OVER], errors + leftover);
    if (errors == 0 && leftover == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
